/* sv/assert_macros.svh */
// Assertion macros used by the checker of the glyph locator.
// No dependencies; take in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on the rising edge, off during reset.
`define FGL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("font_glyph_locator: check failed");

// Next-cycle implication, clocked on the rising edge, off during reset.
`define FGL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("font_glyph_locator: check failed");

`endif

/* sv/fgl_pkg.sv */
// Shared constants, types and the header address table of the glyph locator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fgl_pkg;

   localparam int FONT_BYTES = 4096;
   localparam int MEM_AW     = $clog2(FONT_BYTES);
   // walk pointer: 16-bit jump offset plus one record step
   localparam int P_W        = 17;

   localparam int HDR_BYTES  = 17;
   localparam logic [7:0] EMPTY_MARK = 8'd255;
   localparam logic [7:0] CODE_LO    = 8'd65;
   localparam logic [7:0] CODE_HI    = 8'd97;
   localparam logic [2:0] REC_LONG   = 3'd6;
   localparam logic [2:0] REC_SHORT  = 3'd3;
   localparam logic [7:0] MASK_NARROW = 8'd15;
   localparam logic [7:0] MASK_WIDE   = 8'd255;
   localparam logic [7:0] FMT_LONG_A  = 8'd0;
   localparam logic [7:0] FMT_NARROW  = 8'd1;
   localparam logic [7:0] FMT_LONG_B  = 8'd2;

   // header fetch order
   localparam int HDR_IDX_W = 3;
   localparam logic [HDR_IDX_W-1:0] HDR_FMT    = 3'd0;
   localparam logic [HDR_IDX_W-1:0] HDR_J65_HI = 3'd1;
   localparam logic [HDR_IDX_W-1:0] HDR_J65_LO = 3'd2;
   localparam logic [HDR_IDX_W-1:0] HDR_J97_HI = 3'd3;
   localparam logic [HDR_IDX_W-1:0] HDR_J97_LO = 3'd4;
   localparam logic [HDR_IDX_W-1:0] HDR_FIRST  = 3'd5;
   localparam logic [HDR_IDX_W-1:0] HDR_LAST   = 3'd6;

   typedef enum logic {
      REQ_LOAD   = 1'b0,
      REQ_LOOKUP = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      ADDR_LOAD,
      ADDR_HDR,
      ADDR_P,
      ADDR_P2,
      ADDR_PK
   } addr_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HDR_RD,
      ST_HDR_WAIT,
      ST_START,
      ST_REC_RD,
      ST_REC_WAIT,
      ST_SIZE_WAIT,
      ST_MET_RD,
      ST_MET_WAIT,
      ST_HIT
   } state_type;

   typedef struct packed {
      addr_sel_type addr_sel;
      logic         wr_mem;
      logic         ld_req;
      logic         hdr_cap;
      logic         start_ld;
      logic         p_skip;
      logic         p_adv;
      logic         k_clr;
      logic         rec_cap;
      logic         rsp_hit;
      logic         rsp_miss;
   } dp_cmd_type;

   typedef struct packed {
      logic oob;
      logic hdr_done;
      logic start_miss;
      logic empty;
      logic match;
      logic c_last;
      logic k_last;
   } dp_status_type;

   function automatic logic [3:0] hdr_addr(input logic [HDR_IDX_W-1:0] idx);
      logic [3:0] a;
      a = 4'd0;
      case (idx)
         HDR_FMT:    a = 4'd0;
         HDR_J65_HI: a = 4'd6;
         HDR_J65_LO: a = 4'd7;
         HDR_J97_HI: a = 4'd8;
         HDR_J97_LO: a = 4'd9;
         HDR_FIRST:  a = 4'd10;
         HDR_LAST:   a = 4'd11;
         default:    a = 4'd0;
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

/* sv/fgl_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fgl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* sv/fgl_datapath.sv */
// Datapath of the glyph locator: font memory, header registers, walk pointer
// and code counter, record capture and result registers. Uses fgl_pkg, fgl_ram.
`timescale 1ns / 1ps
`default_nettype none

module fgl_datapath import fgl_pkg::*; (
   input  wire logic            clock,
   input  wire dp_cmd_type      cmd,
   output dp_status_type        status,
   input  wire logic [11:0]     req_load_address,
   input  wire logic [7:0]      req_load_byte,
   input  wire logic [7:0]      req_glyph_code,
   output logic                 rsp_found,
   output logic [7:0]           rsp_box_width,
   output logic [7:0]           rsp_box_height,
   output logic signed [7:0]    rsp_advance,
   output logic signed [7:0]    rsp_x_offset,
   output logic signed [7:0]    rsp_y_offset,
   output logic [11:0]          rsp_bitmap_address
);

   logic [7:0]           code_ff, fmt_ff, first_ff, last_ff, c_ff;
   logic [15:0]          j65_ff, j97_ff;
   logic [P_W-1:0]       p_ff;
   logic [HDR_IDX_W-1:0] hidx_ff;
   logic [2:0]           k_ff;
   logic [7:0]           rec_ff [6];
   logic                 found_ff;
   logic [7:0]           width_ff, height_ff, adv_ff, xo_ff, yo_ff;
   logic [11:0]          bmp_ff;

   logic [P_W-1:0]    addr_full;
   logic [7:0]        rd_data;
   logic              long_rec;
   logic [2:0]        recsz;
   logic [7:0]        size_mask;
   logic              sel97, sel65;
   logic [P_W-1:0]    start_p;
   logic [7:0]        start_c;
   logic [P_W-1:0]    p_step;
   logic [P_W-1:0]    bmp_full;

   assign long_rec  = (fmt_ff == FMT_LONG_A) || (fmt_ff == FMT_LONG_B);
   assign recsz     = long_rec ? REC_LONG : REC_SHORT;
   assign size_mask = (fmt_ff == FMT_NARROW) ? MASK_NARROW : MASK_WIDE;

   always_comb begin
      case (cmd.addr_sel)
         ADDR_LOAD: addr_full = P_W'(req_load_address);
         ADDR_HDR:  addr_full = P_W'(hdr_addr(hidx_ff));
         ADDR_P:    addr_full = p_ff;
         ADDR_P2:   addr_full = p_ff + P_W'(2);
         ADDR_PK:   addr_full = p_ff + P_W'(k_ff);
         default:   addr_full = p_ff;
      endcase
   end

   fgl_ram #(
      .WIDTH (8),
      .DEPTH (FONT_BYTES)
   ) u_font_ram (
      .clock (clock),
      .we    (cmd.wr_mem && !status.oob),
      .addr  (addr_full[MEM_AW-1:0]),
      .wdata (req_load_byte),
      .rdata (rd_data)
   );

   // pick the entry point of the walk
   assign sel97   = (code_ff >= CODE_HI) && (j97_ff != 16'd0);
   assign sel65   = (code_ff >= CODE_LO) && (j65_ff != 16'd0);
   assign start_p = sel97 ? P_W'(j97_ff) : (sel65 ? P_W'(j65_ff) : P_W'(HDR_BYTES));
   assign start_c = sel97 ? CODE_HI : (sel65 ? CODE_LO : first_ff);

   assign p_step   = p_ff + P_W'(rd_data & size_mask) + P_W'(recsz);
   assign bmp_full = p_ff + P_W'(recsz);

   assign status.oob        = addr_full >= P_W'(FONT_BYTES);
   assign status.hdr_done   = hidx_ff == HDR_LAST;
   assign status.start_miss = (code_ff > last_ff) || (start_c > last_ff);
   assign status.empty      = rd_data == EMPTY_MARK;
   assign status.match      = c_ff == code_ff;
   assign status.c_last     = c_ff == last_ff;
   assign status.k_last     = k_ff == (recsz - 3'd1);

   always_ff @(posedge clock) begin
      if (cmd.ld_req) begin
         code_ff <= req_glyph_code;
         hidx_ff <= '0;
      end
      if (cmd.hdr_cap) begin
         hidx_ff <= hidx_ff + HDR_IDX_W'(1);
         case (hidx_ff)
            HDR_FMT:    fmt_ff        <= rd_data;
            HDR_J65_HI: j65_ff[15:8]  <= rd_data;
            HDR_J65_LO: j65_ff[7:0]   <= rd_data;
            HDR_J97_HI: j97_ff[15:8]  <= rd_data;
            HDR_J97_LO: j97_ff[7:0]   <= rd_data;
            HDR_FIRST:  first_ff      <= rd_data;
            HDR_LAST:   last_ff       <= rd_data;
            default:    fmt_ff        <= fmt_ff;
         endcase
      end
      if (cmd.start_ld) begin
         p_ff <= start_p;
         c_ff <= start_c;
      end
      if (cmd.p_skip) begin
         p_ff <= p_ff + P_W'(1);
         c_ff <= c_ff + 8'd1;
      end
      if (cmd.p_adv) begin
         p_ff <= p_step;
         c_ff <= c_ff + 8'd1;
      end
      if (cmd.k_clr) begin
         k_ff <= '0;
      end
      if (cmd.rec_cap) begin
         rec_ff[k_ff] <= rd_data;
         k_ff         <= k_ff + 3'd1;
      end
      if (cmd.rsp_hit) begin
         found_ff <= 1'b1;
         bmp_ff   <= bmp_full[11:0];
         if (long_rec) begin
            width_ff  <= rec_ff[0];
            height_ff <= rec_ff[1];
            adv_ff    <= rec_ff[3];
            xo_ff     <= rec_ff[4];
            yo_ff     <= rec_ff[5];
         end else begin
            width_ff  <= {4'd0, rec_ff[1][7:4]};
            height_ff <= {4'd0, rec_ff[1][3:0]};
            adv_ff    <= {4'd0, rec_ff[2][7:4]};
            xo_ff     <= {4'd0, rec_ff[0][3:0]};
            yo_ff     <= {4'd0, rec_ff[0][7:4]};
         end
      end else if (cmd.rsp_miss) begin
         found_ff  <= 1'b0;
         bmp_ff    <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         adv_ff    <= '0;
         xo_ff     <= '0;
         yo_ff     <= '0;
      end
   end

   assign rsp_found          = found_ff;
   assign rsp_box_width      = width_ff;
   assign rsp_box_height     = height_ff;
   assign rsp_advance        = $signed(adv_ff);
   assign rsp_x_offset       = $signed(xo_ff);
   assign rsp_y_offset       = $signed(yo_ff);
   assign rsp_bitmap_address = bmp_ff;

endmodule

`default_nettype wire

/* sv/fgl_ctrl.sv */
// Sequencer of the glyph locator: header fetch, record walk, metric fetch.
// Drives the datapath by command struct. Uses fgl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fgl_ctrl import fgl_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic          req_type,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd,
   output logic               busy,
   output logic               rsp_strobe
);

   state_type state_ff, state_in;
   logic      strobe_ff, strobe_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.addr_sel = ADDR_P;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_type == REQ_LOAD) begin
                  cmd.wr_mem   = 1'b1;
                  cmd.addr_sel = ADDR_LOAD;
               end else begin
                  cmd.ld_req = 1'b1;
                  state_in   = ST_HDR_RD;
               end
            end
         end
         ST_HDR_RD: begin
            cmd.addr_sel = ADDR_HDR;
            state_in     = ST_HDR_WAIT;
         end
         ST_HDR_WAIT: begin
            cmd.hdr_cap = 1'b1;
            state_in    = status.hdr_done ? ST_START : ST_HDR_RD;
         end
         ST_START: begin
            cmd.start_ld = 1'b1;
            if (status.start_miss) begin
               cmd.rsp_miss = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_REC_RD;
            end
         end
         ST_REC_RD: begin
            cmd.addr_sel = ADDR_P;
            if (status.oob) begin
               cmd.rsp_miss = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_REC_WAIT;
            end
         end
         ST_REC_WAIT: begin
            if (status.empty) begin
               cmd.p_skip = 1'b1;
               if (status.c_last) begin
                  cmd.rsp_miss = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_REC_RD;
               end
            end else if (status.match) begin
               cmd.k_clr = 1'b1;
               state_in  = ST_MET_RD;
            end else begin
               // fetch the size byte straight away
               cmd.addr_sel = ADDR_P2;
               if (status.oob) begin
                  cmd.rsp_miss = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_SIZE_WAIT;
               end
            end
         end
         ST_SIZE_WAIT: begin
            cmd.p_adv = 1'b1;
            if (status.c_last) begin
               cmd.rsp_miss = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_REC_RD;
            end
         end
         ST_MET_RD: begin
            cmd.addr_sel = ADDR_PK;
            if (status.oob) begin
               cmd.rsp_miss = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_MET_WAIT;
            end
         end
         ST_MET_WAIT: begin
            cmd.rec_cap = 1'b1;
            state_in    = status.k_last ? ST_HIT : ST_MET_RD;
         end
         ST_HIT: begin
            cmd.rsp_hit = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign strobe_in  = cmd.rsp_hit || cmd.rsp_miss;
   assign busy       = state_ff != ST_IDLE;
   assign rsp_strobe = strobe_ff;

endmodule

`default_nettype wire

/* sv/font_glyph_locator.sv */
// Top level of the glyph locator: sequencer plus datapath with font memory.
// Depends on fgl_pkg, fgl_ctrl, fgl_datapath, fgl_ram.
//
//  channel   ports                      handshake
//  request   req_type, req_load_*,      accepted when start high and busy low
//            req_glyph_code
//  result    rsp_*                      valid for one cycle while rsp_strobe high
//
// A load gives no result; busy stays low.
// A lookup reads the header entries, picks the entry point, then walks the records:
// it reads the lead byte of each, and of each non-empty record that does not match
// also its size byte; a hit reads each metric byte of the matched record and unpacks.
// The result is shown the cycle after the walk ends, with busy already low, and a
// new transaction may be taken in that cycle; the receiver cannot stall.
// Reset is synchronous and clears the sequencer only.
`timescale 1ns / 1ps
`default_nettype none

module font_glyph_locator import fgl_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire logic         req_type,
   input  wire logic [11:0]  req_load_address,
   input  wire logic [7:0]   req_load_byte,
   input  wire logic [7:0]   req_glyph_code,
   output logic              rsp_strobe,
   output logic              rsp_found,
   output logic [7:0]        rsp_box_width,
   output logic [7:0]        rsp_box_height,
   output logic signed [7:0] rsp_advance,
   output logic signed [7:0] rsp_x_offset,
   output logic signed [7:0] rsp_y_offset,
   output logic [11:0]       rsp_bitmap_address
);

   dp_cmd_type    cmd;
   dp_status_type status;

   fgl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_type   (req_type),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   fgl_datapath u_datapath (
      .clock              (clock),
      .cmd                (cmd),
      .status             (status),
      .req_load_address   (req_load_address),
      .req_load_byte      (req_load_byte),
      .req_glyph_code     (req_glyph_code),
      .rsp_found          (rsp_found),
      .rsp_box_width      (rsp_box_width),
      .rsp_box_height     (rsp_box_height),
      .rsp_advance        (rsp_advance),
      .rsp_x_offset       (rsp_x_offset),
      .rsp_y_offset       (rsp_y_offset),
      .rsp_bitmap_address (rsp_bitmap_address)
   );

endmodule

`default_nettype wire

/* sv/fgl_checker.sv */
// Port-level checks of the glyph locator, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fgl_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         start,
   input wire logic         busy,
   input wire logic         req_type,
   input wire logic [11:0]  req_load_address,
   input wire logic [7:0]   req_load_byte,
   input wire logic [7:0]   req_glyph_code,
   input wire logic         rsp_strobe,
   input wire logic         rsp_found,
   input wire logic [7:0]   rsp_box_width,
   input wire logic [7:0]   rsp_box_height,
   input wire logic signed [7:0] rsp_advance,
   input wire logic signed [7:0] rsp_x_offset,
   input wire logic signed [7:0] rsp_y_offset,
   input wire logic [11:0]  rsp_bitmap_address
);

   // a miss carries all-zero metrics
   `FGL_ASSERT_NOW(a_miss_zero, clock, reset, rsp_strobe && !rsp_found,
      rsp_box_width == 8'd0 && rsp_box_height == 8'd0 && rsp_advance == 8'sd0 &&
      rsp_x_offset == 8'sd0 && rsp_y_offset == 8'sd0 && rsp_bitmap_address == 12'd0)
   // a lookup transaction occupies the block
   `FGL_ASSERT_NEXT(a_lookup_busy, clock, reset, start && !busy && req_type, busy)
   // a load completes in its own cycle
   `FGL_ASSERT_NEXT(a_load_free, clock, reset, start && !busy && !req_type,
      !busy && !rsp_strobe)
   // results follow a busy period and never come back to back
   `FGL_ASSERT_NOW(a_strobe_after_busy, clock, reset, rsp_strobe, $past(busy))
   `FGL_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe)

endmodule

bind font_glyph_locator fgl_checker u_fgl_checker (.*);

`default_nettype wire
